/* hw/rtl/lge_pkg.sv */
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types and constants of the life grid engine: action codes, field
// widths, grid size defaults, the 3x3 window and border flag structs.
// ----------------------------------------------------------------------------
package lge_pkg;

	localparam int ACTION_W = 3;
	localparam int COORD_W  = 6;
	localparam int GEN_W    = 32;

	localparam int GRID_WIDTH_DEF  = 64;
	localparam int GRID_HEIGHT_DEF = 64;

	// action codes; codes above ACT_READ behave as a read
	localparam logic [ACTION_W-1:0] ACT_ADVANCE = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_SET     = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_TOGGLE  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_READ    = 3'd4;

	// B3/S23 neighbor counts
	localparam int NCOUNT_W = 4;
	localparam logic [NCOUNT_W-1:0] BIRTH_COUNT = 4'd3;
	localparam logic [NCOUNT_W-1:0] KEEP_LOW    = 4'd2;
	localparam logic [NCOUNT_W-1:0] KEEP_HIGH   = 4'd3;

	// 3x3 window around the center cell; in each row bit 0 is the right
	// neighbor (higher column), bit 1 the middle, bit 2 the left neighbor
	typedef struct packed {
		logic [2:0] up;
		logic [2:0] mid;
		logic [2:0] dn;
	} win_t;

	// center cell position flags for edge masking
	typedef struct packed {
		logic at_left;
		logic at_right;
		logic at_top;
		logic at_bottom;
	} border_t;

endpackage

/* hw/rtl/lge_window.sv */
// ----------------------------------------------------------------------------
// lge_window
// Chain of one-bit cells, two grid rows plus three long. Cells enter in
// raster order and every cell hands its bit to the next on each shift; fixed
// taps give the 3x3 neighborhood of the cell at the middle of the chain.
// ----------------------------------------------------------------------------
module lge_window #(
	parameter int GRID_WIDTH = lge_pkg::GRID_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          shift_en,
	input  logic          bit_in,
	output lge_pkg::win_t win
);

	localparam int CHAIN_LEN = 2 * GRID_WIDTH + 3;

	logic [CHAIN_LEN-1:0] chain_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			chain_q <= {chain_q[CHAIN_LEN-2:0], bit_in};
		end
	end

	assign win.dn  = chain_q[2:0];
	assign win.mid = chain_q[GRID_WIDTH+2:GRID_WIDTH];
	assign win.up  = chain_q[2*GRID_WIDTH+2:2*GRID_WIDTH];

endmodule

/* hw/rtl/lge_rule.sv */
// ----------------------------------------------------------------------------
// lge_rule
// B3/S23 update of one cell: mask neighbors beyond the grid edges, count the
// live ones and decide birth, survival or death.
// ----------------------------------------------------------------------------
module lge_rule (
	input  lge_pkg::win_t    win,
	input  lge_pkg::border_t border,
	output logic             next_alive
);

	logic [2:0]                     up_m;
	logic [2:0]                     mid_m;
	logic [2:0]                     dn_m;
	logic [lge_pkg::NCOUNT_W-1:0]   live;
	logic                           self_alive;

	always_comb begin
		up_m  = border.at_top    ? 3'b000 : win.up;
		mid_m = win.mid;
		dn_m  = border.at_bottom ? 3'b000 : win.dn;
		if (border.at_left) begin
			up_m[2]  = 1'b0;
			mid_m[2] = 1'b0;
			dn_m[2]  = 1'b0;
		end
		if (border.at_right) begin
			up_m[0]  = 1'b0;
			mid_m[0] = 1'b0;
			dn_m[0]  = 1'b0;
		end
		self_alive = win.mid[1];
		live = lge_pkg::NCOUNT_W'(up_m[0]) + lge_pkg::NCOUNT_W'(up_m[1])
		     + lge_pkg::NCOUNT_W'(up_m[2]) + lge_pkg::NCOUNT_W'(mid_m[0])
		     + lge_pkg::NCOUNT_W'(mid_m[2]) + lge_pkg::NCOUNT_W'(dn_m[0])
		     + lge_pkg::NCOUNT_W'(dn_m[1]) + lge_pkg::NCOUNT_W'(dn_m[2]);
		if (self_alive) begin
			next_alive = live inside {[lge_pkg::KEEP_LOW:lge_pkg::KEEP_HIGH]};
		end else begin
			next_alive = (live == lge_pkg::BIRTH_COUNT);
		end
	end

endmodule

/* hw/rtl/life_grid_engine_top.sv */
// ----------------------------------------------------------------------------
// life_grid_engine_top
// Game of Life (B3/S23) engine on a bounded grid with single-cell access.
// ----------------------------------------------------------------------------
// The grid lives in a one-bit-wide memory of GRID_WIDTH*GRID_HEIGHT entries
// with one read and one write port. After reset a clearing pass writes every
// entry dead, and no request is taken until it ends. A set, clear, toggle or
// read request runs these steps before the next request is taken: read the
// cell, modify and write it back, load the result register. An advance adds
// a sweep ahead of those steps: the sweep reads one cell per cycle from the
// memory port into a chain of one-bit cells two rows plus three long, which
// serves as the snapshot; the rule is applied at the middle of the chain and
// the new cell is written back in place, one cell per cycle, GRID_WIDTH+3
// cells behind the read pointer. Cells beyond the edges count as dead. The
// result register lets a new request in while the previous result still
// waits on rsp_stall.
// ----------------------------------------------------------------------------
module life_grid_engine_top #(
	parameter int GRID_WIDTH  = lge_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = lge_pkg::GRID_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [lge_pkg::ACTION_W-1:0]  action,
	input  logic [lge_pkg::COORD_W-1:0]   col,
	input  logic [lge_pkg::COORD_W-1:0]   row,
	// response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          cell_alive,
	output logic [lge_pkg::GEN_W-1:0]     generation
);

	localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int TW    = $clog2(CELLS + GRID_WIDTH + 4);
	localparam int CXW   = $clog2(GRID_WIDTH);
	localparam int CYW   = $clog2(GRID_HEIGHT);
	// first sweep cycle at which the chain center holds cell 0
	localparam int WR_START = GRID_WIDTH + 3;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_ADV   = 6'b000100,
		ST_READ  = 6'b001000,
		ST_WB    = 6'b010000,
		ST_RESP  = 6'b100000
	} state_t;

	state_t                       state_q;
	logic [lge_pkg::ACTION_W-1:0] act_q;
	logic                         inside_q;
	logic [AW-1:0]                idx_q;
	logic [TW-1:0]                t_q;
	logic [AW-1:0]                wr_addr_q;
	logic [CXW-1:0]               cx_q;
	logic [CYW-1:0]               cy_q;
	logic [lge_pkg::GEN_W-1:0]    gen_q;
	logic                         alive_q;
	logic                         rsp_valid_q;
	logic                         cell_alive_q;
	logic [lge_pkg::GEN_W-1:0]    generation_q;

	// grid memory and its registered read data
	logic                         grid_q [CELLS];
	logic                         rd_data_q;

	logic                         req_acc;
	logic                         inside_d;
	logic [AW-1:0]                idx_d;
	logic                         sweep_wr;
	logic                         sweep_done;
	logic                         rsp_load;
	logic                         mod_bit;
	logic                         mod_we;
	logic                         mem_we;
	logic [AW-1:0]                mem_wa;
	logic                         mem_wd;
	logic [AW-1:0]                mem_ra;
	lge_pkg::win_t                win;
	lge_pkg::border_t             border;
	logic                         rule_bit;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;

	// decode the cell address of the request
	assign inside_d = (32'(col) < GRID_WIDTH) && (32'(row) < GRID_HEIGHT);
	assign idx_d    = inside_d ? AW'(32'(row) * GRID_WIDTH + 32'(col)) : '0;

	// sweep control: write back once the chain center holds a real cell
	assign sweep_wr   = (state_q == ST_ADV) && (t_q >= TW'(WR_START));
	assign sweep_done = sweep_wr && (wr_addr_q == AW'(CELLS - 1));

	assign border.at_left   = (cx_q == '0);
	assign border.at_right  = (cx_q == CXW'(GRID_WIDTH - 1));
	assign border.at_top    = (cy_q == '0);
	assign border.at_bottom = (cy_q == CYW'(GRID_HEIGHT - 1));

	lge_window #(
		.GRID_WIDTH(GRID_WIDTH)
	) u_window (
		.clk      (clk),
		.shift_en (state_q == ST_ADV),
		.bit_in   (rd_data_q),
		.win      (win)
	);

	lge_rule u_rule (
		.win        (win),
		.border     (border),
		.next_alive (rule_bit)
	);

	// single-cell modify on the read data
	always_comb begin
		case (act_q)
			lge_pkg::ACT_SET:    mod_bit = 1'b1;
			lge_pkg::ACT_CLEAR:  mod_bit = 1'b0;
			lge_pkg::ACT_TOGGLE: mod_bit = ~rd_data_q;
			default:             mod_bit = rd_data_q;
		endcase
		mod_we = (state_q == ST_WB) && inside_q
		       && (act_q inside {lge_pkg::ACT_SET, lge_pkg::ACT_CLEAR, lge_pkg::ACT_TOGGLE});
	end

	// memory port steering
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = mod_bit;
		mem_ra = idx_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = t_q[AW-1:0];
				mem_wd = 1'b0;
			end
			ST_ADV: begin
				mem_we = sweep_wr;
				mem_wa = wr_addr_q;
				mem_wd = rule_bit;
				// past the last cell the read data only fills masked taps
				mem_ra = (t_q < TW'(CELLS)) ? t_q[AW-1:0] : '0;
			end
			ST_WB: begin
				mem_we = mod_we;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_q[mem_wa] <= mem_wd;
		end
		rd_data_q <= grid_q[mem_ra];
	end

	// hold the result while stalled; load when the output register is free
	assign rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			t_q         <= '0;
			gen_q       <= 32'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (t_q == TW'(CELLS - 1)) begin
						t_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						t_q     <= '0;
						state_q <= (action == lge_pkg::ACT_ADVANCE) ? ST_ADV : ST_READ;
					end
				end
				ST_ADV: begin
					if (sweep_done) begin
						t_q     <= '0;
						gen_q   <= gen_q + 1'b1;
						state_q <= ST_READ;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload and sweep position registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			act_q     <= action;
			inside_q  <= inside_d;
			idx_q     <= idx_d;
			wr_addr_q <= '0;
			cx_q      <= '0;
			cy_q      <= '0;
		end
		if (sweep_wr) begin
			wr_addr_q <= wr_addr_q + 1'b1;
			if (cx_q == CXW'(GRID_WIDTH - 1)) begin
				cx_q <= '0;
				cy_q <= cy_q + 1'b1;
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
		if (state_q == ST_WB) begin
			alive_q <= inside_q && mod_bit;
		end
		if (rsp_load) begin
			cell_alive_q <= alive_q;
			generation_q <= gen_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign cell_alive = cell_alive_q;
	assign generation = generation_q;

endmodule

/* hw/rtl/lge_checker.sv */
// ----------------------------------------------------------------------------
// lge_checker
// Port-level checks of the life grid engine: response hold, request and
// response balance, and generation stepping between responses.
// ----------------------------------------------------------------------------
module lge_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_stall,
	input logic                      rsp_valid,
	input logic                      rsp_stall,
	input logic                      cell_alive,
	input logic [lge_pkg::GEN_W-1:0] generation
);

	logic                      req_acc;
	logic                      rsp_acc;
	logic [1:0]                pend_q;
	logic                      have_prev_q;
	logic [lge_pkg::GEN_W-1:0] prev_gen_q;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			have_prev_q <= 1'b0;
			prev_gen_q  <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_acc) - 2'(rsp_acc);
			if (rsp_acc) begin
				have_prev_q <= 1'b1;
				prev_gen_q  <= generation;
			end
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(cell_alive) && $stable(generation))
		else $error("response changed while stalled");

	a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an open request");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two requests open");

	a_gen_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc && have_prev_q |->
			(generation == prev_gen_q) || (generation == prev_gen_q + 32'd1))
		else $error("generation stepped by more than one");

	a_gen_first: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc && !have_prev_q |-> (generation == 32'd1) || (generation == 32'd2))
		else $error("first generation after reset out of range");

endmodule

bind life_grid_engine_top lge_checker u_lge_checker (.*);

/* tb/life_grid_engine_top_tb.sv */
// ----------------------------------------------------------------------------
// life_grid_engine_top_tb
// Self-checking bench for the Game of Life engine. It drives set, clear,
// toggle, read and advance requests and keeps its own copy of the 64x64 grid
// and the generation count to predict every response. Directed requests cover
// reset state, grid corners, unused action codes and the no-wrap edges.
// Random requests then seed small windows near edges and corners and let them
// evolve over several generations, mixed with unstructured noise. Both sides
// insert random gaps.
// ----------------------------------------------------------------------------
module life_grid_engine_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ACTION_W   = lge_pkg::ACTION_W;
	localparam int COORD_W    = lge_pkg::COORD_W;
	localparam int GEN_W      = lge_pkg::GEN_W;
	localparam int GRID_W     = lge_pkg::GRID_WIDTH_DEF;
	localparam int GRID_H     = lge_pkg::GRID_HEIGHT_DEF;
	localparam int WIN        = 6;      // side of a seeded window
	localparam int RANDOM_N   = 110;    // random requests after the directed part
	localparam int IDLE_LIMIT = 20000;  // clearing pass or advance plus gaps, with margin
	localparam int MAX_SHOWN  = 10;

	// action codes with no function of their own; they behave as a read
	localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_C = 3'd7;

	typedef struct {
		logic             alive;
		logic [GEN_W-1:0] gen;
	} cell_result_t;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic [ACTION_W-1:0] action;
	logic [COORD_W-1:0]  col;
	logic [COORD_W-1:0]  row;
	logic                rsp_valid;
	logic                rsp_stall;
	logic                cell_alive;
	logic [GEN_W-1:0]    generation;

	// predicted grid, cell (x, y) at bit y*GRID_W + x, and generation count
	logic [GRID_W*GRID_H-1:0] life_cells;
	logic [GEN_W-1:0]         gen_now;
	cell_result_t             pending_results[$];

	int  mismatch_count;
	int  sent_count;
	int  idle_cycles;
	int  stall_left;
	bit  steady_flow;   // suppress gaps on both sides while set

	life_grid_engine_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.col        (col),
		.row        (row),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.cell_alive (cell_alive),
		.generation (generation)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Gap length shared by sender and receiver: mostly none, often short,
	// now and then long enough to straddle a whole request.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Apply B3/S23 to every cell from a frozen copy; cells off the grid
	// are dead, so edge cells simply see fewer neighbors.
	task automatic advance_generation();
		logic [GRID_W*GRID_H-1:0] frozen;
		int                       live;
		frozen = life_cells;
		for (int y = 0; y < GRID_H; y++) begin
			for (int x = 0; x < GRID_W; x++) begin
				live = 0;
				for (int dy = -1; dy <= 1; dy++) begin
					for (int dx = -1; dx <= 1; dx++) begin
						if ((dx != 0 || dy != 0) && x + dx >= 0 && x + dx < GRID_W &&
							y + dy >= 0 && y + dy < GRID_H)
							live += int'(frozen[(y + dy) * GRID_W + x + dx]);
					end
				end
				if (frozen[y * GRID_W + x])
					life_cells[y * GRID_W + x] = (live >= int'(lge_pkg::KEEP_LOW) &&
						live <= int'(lge_pkg::KEEP_HIGH));
				else
					life_cells[y * GRID_W + x] = (live == int'(lge_pkg::BIRTH_COUNT));
			end
		end
		gen_now++;
	endtask

	// Update the grid copy for one accepted request and queue its response.
	task automatic predict_cell_result(input logic [ACTION_W-1:0] act,
		input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		cell_result_t want;
		bit           on_grid;
		int           idx;
		on_grid = (int'(x) < GRID_W) && (int'(y) < GRID_H);
		idx     = on_grid ? int'(y) * GRID_W + int'(x) : 0;
		if (act == lge_pkg::ACT_ADVANCE)
			advance_generation();
		else if (on_grid) begin
			if (act == lge_pkg::ACT_SET)
				life_cells[idx] = 1'b1;
			else if (act == lge_pkg::ACT_CLEAR)
				life_cells[idx] = 1'b0;
			else if (act == lge_pkg::ACT_TOGGLE)
				life_cells[idx] = ~life_cells[idx];
			// read and unused codes leave the grid alone
		end
		want.alive = on_grid ? life_cells[idx] : 1'b0;
		want.gen   = gen_now;
		pending_results.push_back(want);
	endtask

	// ------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------

	// Drive one request at a falling edge, hold it until accepted, then
	// predict it. Valid stays high on exit so a back-to-back request does
	// not drop and raise it in the same step.
	task automatic issue_request(input logic [ACTION_W-1:0] act,
		input int x, input int y);
		int gap;
		gap = idle_length();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		action    <= act;
		col       <= COORD_W'(x);
		row       <= COORD_W'(y);
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		predict_cell_result(act, COORD_W'(x), COORD_W'(y));
		sent_count++;
	endtask

	// ------------------------------------------------------------------
	// Response side: random stall and per-field check
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (steady_flow) begin
			stall_left = 0;
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = idle_length();
			rsp_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic log_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_SHOWN)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk) begin : check_responses
		cell_result_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				log_mismatch("response with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				if (cell_alive !== want.alive)
					log_mismatch($sformatf("cell_alive expected %0b actual %0b",
						want.alive, cell_alive));
				if (generation !== want.gen)
					log_mismatch($sformatf("generation expected %0d actual %0d",
						want.gen, generation));
			end
		end
	end

	// End the run when neither channel moves for too long.
	always @(posedge clk) begin
		if ((req_valid === 1'b1 && req_stall === 1'b0) ||
			(rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** life_grid_engine_top: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Read the four corners and one inner cell after reset; the unused codes must act as reads.
	task automatic test_reset_state();
		issue_request(lge_pkg::ACT_READ, 0, 0);
		issue_request(lge_pkg::ACT_READ, GRID_W - 1, GRID_H - 1);
		issue_request(ACT_SPARE_A, 0, GRID_H - 1);
		issue_request(ACT_SPARE_B, GRID_W - 1, 0);
		issue_request(ACT_SPARE_C, 21, 42);
	endtask

	// Exercise every write action, including a double toggle.
	task automatic test_cell_access();
		issue_request(lge_pkg::ACT_SET, 0, 0);
		issue_request(lge_pkg::ACT_SET, GRID_W - 1, GRID_H - 1);
		issue_request(lge_pkg::ACT_TOGGLE, 42, 21);
		issue_request(lge_pkg::ACT_TOGGLE, 42, 21);
		issue_request(lge_pkg::ACT_CLEAR, GRID_W - 1, GRID_H - 1);
		issue_request(lge_pkg::ACT_SET, GRID_W - 1, 0);
		issue_request(lge_pkg::ACT_TOGGLE, 0, GRID_H - 1);
	endtask

	// Build an L in the top-left corner (birth at (1,1)) next to a pair on
	// the right edge; a wrapping grid would couple them, a bounded one not.
	task automatic test_edge_rule();
		issue_request(lge_pkg::ACT_SET, 1, 0);
		issue_request(lge_pkg::ACT_SET, 0, 1);
		issue_request(lge_pkg::ACT_SET, GRID_W - 1, 1);
		issue_request(lge_pkg::ACT_ADVANCE, 1, 1);
		issue_request(lge_pkg::ACT_ADVANCE, 0, 0);
		issue_request(lge_pkg::ACT_READ, GRID_W - 1, 0);
		issue_request(lge_pkg::ACT_READ, 0, GRID_H - 1);
	endtask

	// Run requests back to back with no gaps and no stall.
	task automatic test_back_to_back();
		steady_flow = 1'b1;
		for (int i = 0; i < 8; i++)
			issue_request(lge_pkg::ACT_TOGGLE, 2 + i, 3);
		issue_request(lge_pkg::ACT_ADVANCE, 4, 3);
		issue_request(lge_pkg::ACT_READ, 5, 4);
		steady_flow = 1'b0;
	endtask

	function automatic int pick_origin(input int span);
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return span - WIN;
			default: return $urandom_range(0, span - WIN);
		endcase
	endfunction

	// Seed a small window (often on an edge or corner), let it evolve for a
	// few generations, then read back inside it.
	task automatic test_seeded_patterns(input int until_count);
		int ox;
		int oy;
		int r;
		logic [ACTION_W-1:0] act;
		while (sent_count < until_count) begin
			ox = pick_origin(GRID_W);
			oy = pick_origin(GRID_H);
			repeat ($urandom_range(5, 10)) begin
				r   = $urandom_range(0, 8);
				act = (r < 6) ? lge_pkg::ACT_SET : (r < 8) ? lge_pkg::ACT_TOGGLE
					: lge_pkg::ACT_CLEAR;
				issue_request(act, ox + $urandom_range(0, WIN - 1),
					oy + $urandom_range(0, WIN - 1));
			end
			repeat ($urandom_range(1, 3))
				issue_request(lge_pkg::ACT_ADVANCE, ox + $urandom_range(0, WIN - 1),
					oy + $urandom_range(0, WIN - 1));
			repeat (2) begin
				act = ACTION_W'($urandom_range(int'(lge_pkg::ACT_READ), int'(ACT_SPARE_C)));
				issue_request(act, ox + $urandom_range(0, WIN - 1),
					oy + $urandom_range(0, WIN - 1));
			end
		end
	endtask

	// Unstructured requests anywhere on the grid; keep advances rare.
	task automatic test_noise(input int until_count);
		logic [ACTION_W-1:0] act;
		while (sent_count < until_count) begin
			if ($urandom_range(0, 9) == 0)
				act = lge_pkg::ACT_ADVANCE;
			else
				act = ACTION_W'($urandom_range(int'(lge_pkg::ACT_SET), int'(ACT_SPARE_C)));
			issue_request(act, $urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1));
		end
	endtask

	// Drop valid, drain outstanding responses, settle, and report.
	task automatic finish_run();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("** life_grid_engine_top: PASSED **");
		else
			$display("** life_grid_engine_top: FAILED **");
		$finish;
	endtask

	initial begin : run_tests
		int random_base;
		// hold every input known from time zero
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		action         = lge_pkg::ACT_READ;
		col            = '0;
		row            = '0;
		rsp_stall      = 1'b0;
		life_cells     = '0;
		gen_now        = 1;
		mismatch_count = 0;
		sent_count     = 0;
		idle_cycles    = 0;
		stall_left     = 0;
		steady_flow    = 1'b0;

		// assert reset, then release it; the clearing pass then holds off requests
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_cell_access();
		test_edge_rule();
		test_back_to_back();

		random_base = sent_count;
		test_seeded_patterns(random_base + (RANDOM_N * 3) / 4);
		test_noise(random_base + RANDOM_N);

		finish_run();
	end

endmodule
